// ===== src/i2cdac_pkg.sv =====
package i2cdac_pkg;

  localparam int unsigned TICKS_W     = 16;
  localparam int unsigned CODE_W      = 12;
  localparam int unsigned PD_W        = 2;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned READ_BEATS  = 5;
  localparam int unsigned BEAT_W      = $clog2(READ_BEATS);

  localparam logic [TICKS_W-1:0] TICKS_RESET = 16'd25;

  typedef enum logic [1:0] {
    ACT_WRITE = 2'd0,
    ACT_READ  = 2'd1,
    ACT_GCALL = 2'd2,
    ACT_TICK  = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    KIND_FAST     = 2'd0,
    KIND_DAC      = 2'd1,
    KIND_DAC_EE   = 2'd2,
    KIND_RESERVED = 2'd3
  } kind_t;

  // 3-bit command field of a non-fast first byte
  localparam logic [2:0] CMD_DAC    = 3'b010;
  localparam logic [2:0] CMD_DAC_EE = 3'b011;

  // Status captured when a read request is taken
  typedef struct packed {
    logic              ready;
    logic [PD_W-1:0]   dac_pd;
    logic [CODE_W-1:0] dac_code;
    logic [PD_W-1:0]   ee_pd;
    logic [CODE_W-1:0] ee_code;
  } status_t;

  typedef struct packed {
    logic    valid;
    status_t snap;
  } q_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// ===== src/i2cdac_front.sv =====
module i2cdac_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [i2cdac_pkg::TICKS_W-1:0] cfg_wdata,
  input  logic                        in_fire,
  input  logic [1:0]                  in_action,
  input  logic [7:0]                  in_data_byte,
  input  logic                        in_stop_after,
  output i2cdac_pkg::q_entry_t        push
);

  logic [i2cdac_pkg::TICKS_W-1:0] ticks_r;
  logic [1:0]                     idx_r, idx_nxt;
  i2cdac_pkg::kind_t              kind_r, kind_nxt;
  logic [i2cdac_pkg::PD_W-1:0]    ppd_r, ppd_nxt;
  logic [i2cdac_pkg::CODE_W-1:0]  pcode_r, pcode_nxt;
  logic [i2cdac_pkg::CODE_W-1:0]  dac_code_r, dac_code_nxt;
  logic [i2cdac_pkg::PD_W-1:0]    dac_pd_r, dac_pd_nxt;
  logic [i2cdac_pkg::CODE_W-1:0]  ee_code_r, ee_code_nxt;
  logic [i2cdac_pkg::PD_W-1:0]    ee_pd_r, ee_pd_nxt;
  logic [i2cdac_pkg::TICKS_W-1:0] busy_r, busy_nxt;
  logic                           fin;

  always_comb begin
    idx_nxt      = idx_r;
    kind_nxt     = kind_r;
    ppd_nxt      = ppd_r;
    pcode_nxt    = pcode_r;
    dac_code_nxt = dac_code_r;
    dac_pd_nxt   = dac_pd_r;
    ee_code_nxt  = ee_code_r;
    ee_pd_nxt    = ee_pd_r;
    busy_nxt     = busy_r;
    fin          = 1'b0;

    push.valid         = 1'b0;
    push.snap.ready    = (busy_r == '0);
    push.snap.dac_pd   = dac_pd_r;
    push.snap.dac_code = dac_code_r;
    push.snap.ee_pd    = ee_pd_r;
    push.snap.ee_code  = ee_code_r;

    if (in_fire) begin
      unique case (i2cdac_pkg::action_t'(in_action))
        i2cdac_pkg::ACT_WRITE: begin
          unique case (idx_r)
            2'd1: begin
              if (kind_r == i2cdac_pkg::KIND_FAST) begin
                pcode_nxt = {pcode_r[11:8], in_data_byte};
                fin       = 1'b1;
              end else begin
                pcode_nxt = {in_data_byte, 4'b0000};
                idx_nxt   = 2'd2;
              end
            end
            2'd2: begin
              pcode_nxt = {pcode_r[11:4], in_data_byte[7:4]};
              fin       = 1'b1;
            end
            default: begin
              if (in_data_byte[7:6] == 2'b00) begin
                kind_nxt  = i2cdac_pkg::KIND_FAST;
                ppd_nxt   = in_data_byte[5:4];
                pcode_nxt = {in_data_byte[3:0], 8'h00};
              end else begin
                unique case (in_data_byte[7:5])
                  i2cdac_pkg::CMD_DAC:    kind_nxt = i2cdac_pkg::KIND_DAC;
                  i2cdac_pkg::CMD_DAC_EE: kind_nxt = i2cdac_pkg::KIND_DAC_EE;
                  default:                kind_nxt = i2cdac_pkg::KIND_RESERVED;
                endcase
                ppd_nxt = in_data_byte[2:1];
              end
              idx_nxt = 2'd1;
            end
          endcase

          if (fin) begin
            idx_nxt = 2'd0;
            unique case (kind_r) inside
              i2cdac_pkg::KIND_FAST, i2cdac_pkg::KIND_DAC: begin
                dac_code_nxt = pcode_nxt;
                dac_pd_nxt   = ppd_r;
              end
              i2cdac_pkg::KIND_DAC_EE: begin
                // drop the whole frame while the EEPROM is still busy
                if (busy_r == '0) begin
                  dac_code_nxt = pcode_nxt;
                  dac_pd_nxt   = ppd_r;
                  ee_code_nxt  = pcode_nxt;
                  ee_pd_nxt    = ppd_r;
                  busy_nxt     = ticks_r;
                end
              end
              default: ;
            endcase
          end

          if (in_stop_after) begin
            idx_nxt = 2'd0;
          end
        end
        i2cdac_pkg::ACT_READ: begin
          idx_nxt    = 2'd0;
          push.valid = 1'b1;
        end
        i2cdac_pkg::ACT_GCALL: begin
          idx_nxt      = 2'd0;
          dac_code_nxt = ee_code_r;
          dac_pd_nxt   = ee_pd_r;
        end
        default: begin
          if (busy_r != '0) begin
            busy_nxt = busy_r - 1'b1;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ticks_r    <= i2cdac_pkg::TICKS_RESET;
      idx_r      <= '0;
      kind_r     <= i2cdac_pkg::KIND_FAST;
      ppd_r      <= '0;
      pcode_r    <= '0;
      dac_code_r <= '0;
      dac_pd_r   <= '0;
      ee_code_r  <= '0;
      ee_pd_r    <= '0;
      busy_r     <= '0;
    end else begin
      if (cfg_we) begin
        ticks_r <= cfg_wdata;
      end
      idx_r      <= idx_nxt;
      kind_r     <= kind_nxt;
      ppd_r      <= ppd_nxt;
      pcode_r    <= pcode_nxt;
      dac_code_r <= dac_code_nxt;
      dac_pd_r   <= dac_pd_nxt;
      ee_code_r  <= ee_code_nxt;
      ee_pd_r    <= ee_pd_nxt;
      busy_r     <= busy_nxt;
    end
  end

endmodule

// ===== src/i2cdac_fifo.sv =====
module i2cdac_fifo #(
  parameter int unsigned DEPTH = i2cdac_pkg::QUEUE_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  i2cdac_pkg::q_entry_t push,
  input  logic                 pop,
  output i2cdac_pkg::q_entry_t head,
  output i2cdac_pkg::q_stat_t  stat
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  i2cdac_pkg::status_t mem [DEPTH];
  logic [PTR_W-1:0]    wptr_r, wptr_nxt;
  logic [PTR_W-1:0]    rptr_r, rptr_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic                do_push, do_pop;

  assign stat.full  = (cnt_r == CNT_W'(DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign do_push    = push.valid && !stat.full;
  assign do_pop     = pop && !stat.empty;

  assign head.valid = !stat.empty;
  assign head.snap  = mem[rptr_r];

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (do_push) begin
      wptr_nxt = (wptr_r == PTR_W'(DEPTH - 1)) ? '0 : wptr_r + 1'b1;
    end
    if (do_pop) begin
      rptr_nxt = (rptr_r == PTR_W'(DEPTH - 1)) ? '0 : rptr_r + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wptr_r] <= push.snap;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

endmodule

// ===== src/i2cdac_back.sv =====
module i2cdac_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  i2cdac_pkg::q_entry_t head,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [7:0]           out_read_byte,
  output logic                 out_last_of_read
);

  localparam logic [i2cdac_pkg::BEAT_W-1:0] LAST_BEAT =
    i2cdac_pkg::BEAT_W'(i2cdac_pkg::READ_BEATS - 1);

  logic                            act_r, act_nxt;
  logic [i2cdac_pkg::BEAT_W-1:0]   beat_r, beat_nxt;
  i2cdac_pkg::status_t             snap_r;
  logic                            last;

  assign last             = (beat_r == LAST_BEAT);
  assign out_valid        = act_r;
  assign out_last_of_read = act_r && last;

  // load the next burst in the cycle the last beat leaves
  assign pop = head.valid && (!act_r || (out_ready && last));

  always_comb begin
    act_nxt  = act_r;
    beat_nxt = beat_r;
    if (pop) begin
      act_nxt  = 1'b1;
      beat_nxt = '0;
    end else if (act_r && out_ready) begin
      if (last) begin
        act_nxt = 1'b0;
      end else begin
        beat_nxt = beat_r + 1'b1;
      end
    end
  end

  always_comb begin
    case (beat_r)
      3'd0:    out_read_byte = {snap_r.ready, 1'b1, 3'b000, snap_r.dac_pd, 1'b0};
      3'd1:    out_read_byte = snap_r.dac_code[11:4];
      3'd2:    out_read_byte = {snap_r.dac_code[3:0], 4'b0000};
      3'd3:    out_read_byte = {1'b0, snap_r.ee_pd, 1'b0, snap_r.ee_code[11:8]};
      default: out_read_byte = snap_r.ee_code[7:0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      snap_r <= head.snap;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r  <= 1'b0;
      beat_r <= '0;
    end else begin
      act_r  <= act_nxt;
      beat_r <= beat_nxt;
    end
  end

endmodule

// ===== src/i2c_dac_with_eeprom_registers.sv =====
// Channel   Direction  Handshake               Payload
// in_       input      in_valid / in_ready     in_action, in_data_byte, in_stop_after
// out_      output     out_valid / out_ready   out_read_byte, out_last_of_read
// cfg_      input      cfg_we                  cfg_wdata (EEPROM write ticks)
//
// Write bytes, general-call resets and ticks can be accepted back to back while in_ready is high.
// A read request snapshots the status into a queue; the burst unit sends 5 beats,
// one per cycle while out_ready is high, after the snapshot passes the queue into the burst unit.
// in_ready drops only while the status queue (QUEUE_DEPTH entries) is full.
// Reset is synchronous, active low; it clears all state but the queue storage and burst snapshot, and sets ticks to 25.
module i2c_dac_with_eeprom_registers #(
  parameter int unsigned QUEUE_DEPTH = i2cdac_pkg::QUEUE_DEPTH
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [i2cdac_pkg::TICKS_W-1:0] cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [1:0]                     in_action,
  input  logic [7:0]                     in_data_byte,
  input  logic                           in_stop_after,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [7:0]                     out_read_byte,
  output logic                           out_last_of_read
);

  i2cdac_pkg::q_entry_t q_push;
  i2cdac_pkg::q_entry_t q_head;
  i2cdac_pkg::q_stat_t  q_stat;
  logic                 q_pop;
  logic                 in_fire;

  assign in_ready = !q_stat.full;
  assign in_fire  = in_valid && in_ready;

  i2cdac_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .in_fire       (in_fire),
    .in_action     (in_action),
    .in_data_byte  (in_data_byte),
    .in_stop_after (in_stop_after),
    .push          (q_push)
  );

  i2cdac_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .pop   (q_pop),
    .head  (q_head),
    .stat  (q_stat)
  );

  i2cdac_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .head             (q_head),
    .pop              (q_pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_read_byte    (out_read_byte),
    .out_last_of_read (out_last_of_read)
  );

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_push.valid |-> !q_stat.full)
    else $error("status pushed into full queue");

  a_burst_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last_of_read |=> out_valid)
    else $error("read burst broke off before its last beat");

  a_read_queued: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && (in_action == i2cdac_pkg::ACT_READ) |=> !q_stat.empty || out_valid)
    else $error("accepted read request was lost");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_stat.empty)
    else $error("burst unit loaded from empty queue");

endmodule

// ===== tb/dac_status_checker.sv =====
`timescale 1ns / 1ps

module dac_status_checker
  import i2cdac_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [TICKS_W-1:0] cfg_wdata,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [1:0]         in_action,
  input  logic [7:0]         in_data_byte,
  input  logic               in_stop_after,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [7:0]         out_read_byte,
  input  logic               out_last_of_read,
  output int unsigned        beats_pending,
  output int unsigned        fail_count
);

  typedef struct packed {
    logic [7:0] data;
    logic       is_last;
  } status_beat_t;

  status_beat_t status_beats_q[$];

  logic [TICKS_W-1:0] write_ticks;
  logic [1:0]         frame_pos;
  kind_t              frame_kind;
  logic [PD_W-1:0]    frame_pd;
  logic [CODE_W-1:0]  frame_code;
  logic [CODE_W-1:0]  dac_code;
  logic [PD_W-1:0]    dac_pd;
  logic [CODE_W-1:0]  ee_code;
  logic [PD_W-1:0]    ee_pd;
  logic [TICKS_W-1:0] busy_left;

  function automatic void commit_frame();
    case (frame_kind)
      KIND_FAST, KIND_DAC: begin
        dac_code = frame_code;
        dac_pd   = frame_pd;
      end
      KIND_DAC_EE: begin
        // drop the whole frame while the EEPROM is still programming
        if (busy_left == '0) begin
          dac_code  = frame_code;
          dac_pd    = frame_pd;
          ee_code   = frame_code;
          ee_pd     = frame_pd;
          busy_left = write_ticks;
        end
      end
      default: ;
    endcase
    frame_pos = 2'd0;
  endfunction

  function automatic void take_write_byte(input logic [7:0] b);
    case (frame_pos)
      2'd1: begin
        if (frame_kind == KIND_FAST) begin
          frame_code[7:0] = b;
          commit_frame();
        end else begin
          frame_code = {b, 4'h0};
          frame_pos  = 2'd2;
        end
      end
      2'd2: begin
        frame_code[3:0] = b[7:4];
        commit_frame();
      end
      default: begin
        if (b[7:6] == 2'b00) begin
          frame_kind = KIND_FAST;
          frame_pd   = b[5:4];
          frame_code = {b[3:0], 8'h00};
        end else begin
          case (b[7:5])
            CMD_DAC:    frame_kind = KIND_DAC;
            CMD_DAC_EE: frame_kind = KIND_DAC_EE;
            default:    frame_kind = KIND_RESERVED;
          endcase
          frame_pd = b[2:1];
        end
        frame_pos = 2'd1;
      end
    endcase
  endfunction

  function automatic void queue_status_read();
    logic [7:0]   bytes [READ_BEATS];
    status_beat_t beat;
    bytes[0] = {busy_left == '0, 1'b1, 3'b000, dac_pd, 1'b0};
    bytes[1] = dac_code[11:4];
    bytes[2] = {dac_code[3:0], 4'h0};
    bytes[3] = {1'b0, ee_pd, 1'b0, ee_code[11:8]};
    bytes[4] = ee_code[7:0];
    for (int k = 0; k < READ_BEATS; k++) begin
      beat.data    = bytes[k];
      beat.is_last = (k == READ_BEATS - 1);
      status_beats_q.push_back(beat);
    end
  endfunction

  always @(posedge clk) begin
    status_beat_t want;
    if (!rst_n) begin
      write_ticks = TICKS_RESET;
      frame_pos   = 2'd0;
      frame_kind  = KIND_FAST;
      frame_pd    = '0;
      frame_code  = '0;
      dac_code    = '0;
      dac_pd      = '0;
      ee_code     = '0;
      ee_pd       = '0;
      busy_left   = '0;
      status_beats_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (status_beats_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: read beat %h (last %b) with nothing expected",
                     $realtime, out_read_byte, out_last_of_read);
        end else begin
          want = status_beats_q.pop_front();
          if (out_read_byte !== want.data || out_last_of_read !== want.is_last) begin
            fail_count++;
            if (fail_count <= 10)
              $display("%0t: read beat expected byte %h last %b, got byte %h last %b",
                       $realtime, want.data, want.is_last, out_read_byte,
                       out_last_of_read);
          end
        end
      end
      if (cfg_we)
        write_ticks = cfg_wdata;
      if (in_valid && in_ready) begin
        case (action_t'(in_action))
          ACT_WRITE: begin
            take_write_byte(in_data_byte);
            if (in_stop_after)
              frame_pos = 2'd0;
          end
          ACT_READ: begin
            frame_pos = 2'd0;
            queue_status_read();
          end
          ACT_GCALL: begin
            frame_pos = 2'd0;
            dac_code  = ee_code;
            dac_pd    = ee_pd;
          end
          default: begin
            if (busy_left != '0)
              busy_left = busy_left - 1'b1;
          end
        endcase
      end
    end
    beats_pending = status_beats_q.size();
  end

endmodule

// ===== tb/tb_i2c_dac_with_eeprom_registers.sv =====
`timescale 1ns / 1ps

module tb_i2c_dac_with_eeprom_registers;
  import i2cdac_pkg::*;

  logic               clk;
  logic               rst_n         = 1'b0;
  logic               cfg_we        = 1'b0;
  logic [TICKS_W-1:0] cfg_wdata     = '0;
  logic               in_valid      = 1'b0;
  logic               in_ready;
  logic [1:0]         in_action     = ACT_TICK;
  logic [7:0]         in_data_byte  = 8'h00;
  logic               in_stop_after = 1'b0;
  logic               out_valid;
  logic               out_ready     = 1'b0;
  logic [7:0]         out_read_byte;
  logic               out_last_of_read;

  int unsigned beats_pending;
  int unsigned fail_count;
  int unsigned send_idle_pct = 35;
  int unsigned recv_idle_pct = 61;

  i2c_dac_with_eeprom_registers u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_action        (in_action),
    .in_data_byte     (in_data_byte),
    .in_stop_after    (in_stop_after),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_read_byte    (out_read_byte),
    .out_last_of_read (out_last_of_read)
  );

  dac_status_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_action        (in_action),
    .in_data_byte     (in_data_byte),
    .in_stop_after    (in_stop_after),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_read_byte    (out_read_byte),
    .out_last_of_read (out_last_of_read),
    .beats_pending    (beats_pending),
    .fail_count       (fail_count)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic send_item(input action_t act, input logic [7:0] b, input logic s);
    logic taken;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_action     <= act;
    in_data_byte  <= b;
    in_stop_after <= s;
    // sample ready mid-cycle, the beat goes at the following edge
    do begin
      @(negedge clk);
      taken = in_ready;
      @(posedge clk);
    end while (!taken);
  endtask

  task automatic wait_drained();
    do @(negedge clk); while (beats_pending != 0);
    repeat (6) @(posedge clk);
  endtask

  task automatic run_traffic(input int unsigned n_items);
    int unsigned sent;
    int unsigned n;
    int unsigned cut;
    int unsigned pick;
    logic [7:0]  hdr;
    logic [7:0]  b;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(99);
      if (pick < 45) begin
        hdr = 8'($urandom_range(255));
        n   = 3;
        case ($urandom_range(3))
          0: begin
            hdr[7:6] = 2'b00;
            n = 2;
          end
          1:       hdr[7:5] = CMD_DAC;
          2:       hdr[7:5] = CMD_DAC_EE;
          default: hdr[7]   = 1'b1;
        endcase
        // now and then break the frame off early
        cut = ($urandom_range(7) == 0) ? $urandom_range(1, n - 1) : n;
        for (int unsigned k = 0; k < cut; k++) begin
          if (k == 0) b = hdr;
          else        b = 8'($urandom_range(255));
          send_item(ACT_WRITE, b, (k == cut - 1) ? ($urandom_range(3) != 0) : 1'b0);
        end
        sent += cut;
      end else if (pick < 60) begin
        send_item(ACT_READ, 8'($urandom_range(255)), 1'($urandom_range(1)));
        sent++;
      end else if (pick < 65) begin
        send_item(ACT_GCALL, 8'($urandom_range(255)), 1'($urandom_range(1)));
        sent++;
      end else if (pick < 90) begin
        n = ($urandom_range(7) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 6);
        repeat (n) send_item(ACT_TICK, 8'($urandom_range(255)), 1'($urandom_range(1)));
        sent += n;
      end else begin
        send_item(action_t'($urandom_range(3)), 8'($urandom_range(255)),
                  1'($urandom_range(1)));
        sent++;
      end
    end
  endtask

  initial begin
    int unsigned        ph;
    logic [TICKS_W-1:0] ticks_v;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // tick with the EEPROM ready, then the reset status
    send_item(ACT_TICK, 8'hA5, 1'b1);
    send_item(ACT_READ, 8'h5A, 1'b0);
    // fast write, all ones
    send_item(ACT_WRITE, 8'h3F, 1'b0);
    send_item(ACT_WRITE, 8'hFF, 1'b1);
    // DAC write, code zero, low nibble of the last byte ignored
    send_item(ACT_WRITE, 8'h5F, 1'b0);
    send_item(ACT_WRITE, 8'h00, 1'b0);
    send_item(ACT_WRITE, 8'h0F, 1'b1);
    // DAC and EEPROM write, then read while busy
    send_item(ACT_WRITE, 8'h62, 1'b0);
    send_item(ACT_WRITE, 8'h12, 1'b0);
    send_item(ACT_WRITE, 8'h3F, 1'b1);
    send_item(ACT_READ, 8'hFF, 1'b1);
    // EEPROM write while busy: ignored
    send_item(ACT_WRITE, 8'h7C, 1'b0);
    send_item(ACT_WRITE, 8'hFF, 1'b0);
    send_item(ACT_WRITE, 8'hF0, 1'b1);
    // reserved command
    send_item(ACT_WRITE, 8'hFE, 1'b0);
    send_item(ACT_WRITE, 8'h55, 1'b0);
    send_item(ACT_WRITE, 8'h50, 1'b1);
    // stop inside a frame
    send_item(ACT_WRITE, 8'h05, 1'b1);
    // back-to-back frames with no stop, then a read cuts a DAC frame
    send_item(ACT_WRITE, 8'h21, 1'b0);
    send_item(ACT_WRITE, 8'h34, 1'b0);
    send_item(ACT_WRITE, 8'h4A, 1'b0);
    send_item(ACT_READ, 8'h00, 1'b0);
    // general call, also one that cuts a frame
    send_item(ACT_GCALL, 8'h00, 1'b0);
    send_item(ACT_WRITE, 8'h70, 1'b0);
    send_item(ACT_GCALL, 8'hFF, 1'b1);
    send_item(ACT_TICK, 8'h00, 1'b0);
    send_item(ACT_READ, 8'h81, 1'b0);
    in_valid <= 1'b0;

    for (ph = 0; ph < 5; ph++) begin
      wait_drained();
      case (ph)
        0:       ticks_v = 16'd1;
        1:       ticks_v = 16'd0;
        2:       ticks_v = 16'd3;
        3:       ticks_v = TICKS_W'($urandom_range(2, 40));
        default: ticks_v = 16'hFFFF;
      endcase
      if (ph == 2) begin
        send_idle_pct = 61;
        recv_idle_pct <= 35;
      end else if (ph == 4) begin
        send_idle_pct = 0;
        recv_idle_pct <= 0;
      end
      cfg_we    <= 1'b1;
      cfg_wdata <= ticks_v;
      @(posedge clk);
      cfg_we <= 1'b0;
      run_traffic(56);
      in_valid <= 1'b0;
    end

    wait_drained();
    @(negedge clk);
    if (fail_count == 0)
      $display("tb_i2c_dac_with_eeprom_registers passed");
    else
      $display("tb_i2c_dac_with_eeprom_registers failed");
    $finish;
  end

  initial begin
    #2_400_000;
    $display("tb_i2c_dac_with_eeprom_registers failed");
    $finish;
  end

endmodule
